// ===== rtl/imurpp_pkg.sv =====
// Package for the IMU response packet parser.
// Holds the shared types, the word store geometry and the register indexes.
`default_nettype none

package imurpp_pkg;

  localparam int STORE_DEPTH  = 19;
  localparam int STORE_BANKS  = 2;
  localparam int STORE_ADDR_W = $clog2(STORE_DEPTH * STORE_BANKS);
  localparam int WORD_IDX_W   = 5;

  localparam logic [1:0] REG_MEAS_CODE  = 2'd0;
  localparam logic [1:0] REG_ACCEL_CODE = 2'd1;
  localparam logic [1:0] REG_GYRO_CODE  = 2'd2;

  localparam logic [7:0] MEAS_CODE_RST  = 8'd200;
  localparam logic [7:0] ACCEL_CODE_RST = 8'd201;
  localparam logic [7:0] GYRO_CODE_RST  = 8'd205;

  typedef enum logic [1:0] {
    KIND_MEAS  = 2'd0,
    KIND_ACCEL = 2'd1,
    KIND_GYRO  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] meas;
    logic [7:0] accel;
    logic [7:0] gyro;
  } codes_t;

  typedef struct packed {
    kind_t                  kind;
    logic                   bank;
    logic [WORD_IDX_W-1:0]  words;
  } job_t;

  typedef struct packed {
    logic                    en;
    logic [STORE_ADDR_W-1:0] addr;
    logic [31:0]             data;
  } store_wr_t;

  typedef struct packed {
    logic empty;
    logic full;
  } jobq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/imurpp_front.sv =====
// Byte parser: classifies packets, sums bytes, assembles words into the store.
// Pushes a drain job for every packet whose checksum matches. Uses imurpp_pkg.
`default_nettype none

module imurpp_front #(
  parameter int MEAS_PACKET_BYTES = 79,
  parameter int BIAS_PACKET_BYTES = 19
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire imurpp_pkg::codes_t    codes,
  input  wire logic                  byte_valid,
  output logic                       byte_stall,
  input  wire logic [7:0]            rx_byte,
  input  wire logic                  packet_start,
  input  wire imurpp_pkg::jobq_stat_t q_stat,
  output logic                       push,
  output imurpp_pkg::job_t           push_job,
  output imurpp_pkg::store_wr_t      store_wr
);
  import imurpp_pkg::*;

  localparam int MEAS_LEN = (MEAS_PACKET_BYTES < 7) ? 7 :
                            (MEAS_PACKET_BYTES > 127) ? 127 : MEAS_PACKET_BYTES;
  localparam int BIAS_LEN = (BIAS_PACKET_BYTES < 7) ? 7 :
                            (BIAS_PACKET_BYTES > 127) ? 127 : BIAS_PACKET_BYTES;
  localparam int MEAS_WORDS = ((MEAS_LEN - 3) / 4 > STORE_DEPTH) ? STORE_DEPTH
                                                                 : (MEAS_LEN - 3) / 4;
  localparam int BIAS_WORDS = ((BIAS_LEN - 3) / 4 > STORE_DEPTH) ? STORE_DEPTH
                                                                 : (BIAS_LEN - 3) / 4;

  logic                  in_packet;
  kind_t                 kind_latched;
  logic [6:0]            byte_position;
  logic [15:0]           running_sum;
  logic [23:0]           word_shift;
  logic [7:0]            checksum_high;
  logic                  wr_bank;

  logic                  accept;
  logic [6:0]            len;
  logic [6:0]            len_m2;
  logic [6:0]            pay_pos;
  logic [WORD_IDX_W-1:0] word_idx;
  logic                  word_done;
  logic                  is_payload;
  logic                  is_chk_high;
  logic                  is_final;
  logic                  sum_ok;

  assign byte_stall = q_stat.full;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    len         = (kind_latched == KIND_MEAS) ? 7'(MEAS_LEN) : 7'(BIAS_LEN);
    len_m2      = len - 7'd2;
    pay_pos     = byte_position - 7'd1;
    word_idx    = pay_pos[6:2];
    word_done   = (pay_pos[1:0] == 2'b11);
    is_payload  = accept && !packet_start && in_packet && (byte_position < len_m2);
    is_chk_high = accept && !packet_start && in_packet && (byte_position == len_m2);
    is_final    = accept && !packet_start && in_packet && (byte_position > len_m2);
    sum_ok      = ({checksum_high, rx_byte} == running_sum);

    push           = is_final && sum_ok;
    push_job.kind  = kind_latched;
    push_job.bank  = wr_bank;
    push_job.words = (kind_latched == KIND_MEAS) ? WORD_IDX_W'(MEAS_WORDS)
                                                 : WORD_IDX_W'(BIAS_WORDS);

    store_wr.en   = is_payload && word_done && (word_idx < WORD_IDX_W'(STORE_DEPTH));
    store_wr.addr = {1'b0, word_idx} + (wr_bank ? STORE_ADDR_W'(STORE_DEPTH)
                                                : STORE_ADDR_W'(0));
    store_wr.data = {word_shift, rx_byte};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet     <= 1'b0;
      kind_latched  <= KIND_MEAS;
      byte_position <= 7'd0;
      running_sum   <= 16'd0;
      word_shift    <= 24'd0;
      checksum_high <= 8'd0;
      wr_bank       <= 1'b0;
    end else if (accept) begin
      if (packet_start) begin
        if (rx_byte == codes.meas || rx_byte == codes.accel || rx_byte == codes.gyro) begin
          in_packet     <= 1'b1;
          byte_position <= 7'd1;
          running_sum   <= {8'd0, rx_byte};
          word_shift    <= 24'd0;
          checksum_high <= 8'd0;
          if (rx_byte == codes.meas) begin
            kind_latched <= KIND_MEAS;
          end else if (rx_byte == codes.accel) begin
            kind_latched <= KIND_ACCEL;
          end else begin
            kind_latched <= KIND_GYRO;
          end
        end else begin
          in_packet <= 1'b0;
        end
      end else if (is_payload) begin
        running_sum   <= running_sum + {8'd0, rx_byte};
        word_shift    <= word_done ? 24'd0 : {word_shift[15:0], rx_byte};
        byte_position <= byte_position + 7'd1;
      end else if (is_chk_high) begin
        checksum_high <= rx_byte;
        byte_position <= byte_position + 7'd1;
      end else if (is_final) begin
        in_packet     <= 1'b0;
        byte_position <= 7'd0;
        if (sum_ok) begin
          wr_bank <= ~wr_bank;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imurpp_jobq.sv =====
// Two-entry job queue between the byte parser and the word drain.
// One entry per word store bank. Uses imurpp_pkg.
`default_nettype none

module imurpp_jobq (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  input  wire imurpp_pkg::job_t        push_job,
  input  wire logic                    pop,
  output imurpp_pkg::job_t             head,
  output imurpp_pkg::jobq_stat_t       stat
);
  import imurpp_pkg::*;

  job_t       entry [STORE_BANKS];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign stat.empty = (count == 2'd0);
  assign stat.full  = (count == 2'd2);
  assign head       = entry[rd_ptr];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imurpp_drain.sv =====
// Word store (two banks) and the drain that emits the words of queued jobs.
// The store read register is the output word register. Uses imurpp_pkg.
`default_nettype none

module imurpp_drain (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire imurpp_pkg::store_wr_t   store_wr,
  input  wire imurpp_pkg::job_t        head,
  input  wire imurpp_pkg::jobq_stat_t  q_stat,
  output logic                         pop,
  output logic                         word_valid,
  input  wire logic                    word_stall,
  output logic [1:0]                   packet_kind,
  output logic [4:0]                   word_index,
  output logic [31:0]                  word_value,
  output logic                         last_word
);
  import imurpp_pkg::*;

  logic [31:0]             store [STORE_DEPTH * STORE_BANKS];
  logic [WORD_IDX_W-1:0]   k;
  logic                    issue;
  logic                    is_last;
  logic [STORE_ADDR_W-1:0] rd_addr;

  always_comb begin
    issue   = !q_stat.empty && (!word_valid || !word_stall);
    is_last = (k == head.words - WORD_IDX_W'(1));
    pop     = issue && is_last;
    rd_addr = {1'b0, k} + (head.bank ? STORE_ADDR_W'(STORE_DEPTH) : STORE_ADDR_W'(0));
  end

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      store[store_wr.addr] <= store_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      word_value  <= store[rd_addr];
      packet_kind <= head.kind;
      word_index  <= k;
      last_word   <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      k          <= '0;
    end else begin
      if (issue) begin
        word_valid <= 1'b1;
        k          <= is_last ? '0 : k + WORD_IDX_W'(1);
      end else if (!word_stall) begin
        word_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imu_response_packet_parser.sv =====
// The first word of a good packet is shown once its job is registered in the job queue
// and the word is read into the output word register, when the drain is idle.
// Throughput: 1 byte per cycle in and 1 word per cycle out, each while not stalled.
// Input stalls only while both word store banks hold packets still waiting to drain.
// Reset clears parser and drain control and loads code registers with 200, 201 and 205.
// The word store has no reset and needs no clearing pass.
`default_nettype none

module imu_response_packet_parser #(
  parameter int MEAS_PACKET_BYTES = 79,
  parameter int BIAS_PACKET_BYTES = 19
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        packet_start,
  output logic             word_valid,
  input  wire logic        word_stall,
  output logic [1:0]       packet_kind,
  output logic [4:0]       word_index,
  output logic [31:0]      word_value,
  output logic             last_word
);
  import imurpp_pkg::*;

  codes_t     codes;
  logic       cfg_wr;
  logic       q_push;
  job_t       q_push_job;
  logic       q_pop;
  job_t       q_head;
  jobq_stat_t q_stat;
  store_wr_t  store_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      codes.meas  <= MEAS_CODE_RST;
      codes.accel <= ACCEL_CODE_RST;
      codes.gyro  <= GYRO_CODE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MEAS_CODE:  codes.meas  <= pwdata[7:0];
        REG_ACCEL_CODE: codes.accel <= pwdata[7:0];
        REG_GYRO_CODE:  codes.gyro  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MEAS_CODE:  prdata = {24'd0, codes.meas};
      REG_ACCEL_CODE: prdata = {24'd0, codes.accel};
      REG_GYRO_CODE:  prdata = {24'd0, codes.gyro};
      default:        prdata = 32'd0;
    endcase
  end

  imurpp_front #(
    .MEAS_PACKET_BYTES (MEAS_PACKET_BYTES),
    .BIAS_PACKET_BYTES (BIAS_PACKET_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .codes        (codes),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .rx_byte      (rx_byte),
    .packet_start (packet_start),
    .q_stat       (q_stat),
    .push         (q_push),
    .push_job     (q_push_job),
    .store_wr     (store_wr)
  );

  imurpp_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  imurpp_drain u_drain (
    .clk         (clk),
    .rst         (rst),
    .store_wr    (store_wr),
    .head        (q_head),
    .q_stat      (q_stat),
    .pop         (q_pop),
    .word_valid  (word_valid),
    .word_stall  (word_stall),
    .packet_kind (packet_kind),
    .word_index  (word_index),
    .word_value  (word_value),
    .last_word   (last_word)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("job pushed into a full queue");

  a_store_write_not_draining: assert property (@(posedge clk) disable iff (rst)
    (store_wr.en && !q_stat.empty) |-> (q_head.bank != q_push_job.bank))
    else $error("word written into a bank that is still draining");

  a_index_advances: assert property (@(posedge clk) disable iff (rst)
    (word_valid && !word_stall && !last_word) |=>
      (word_valid && word_index == $past(word_index) + 5'd1))
    else $error("word index did not advance within a packet");

  a_index_restarts: assert property (@(posedge clk) disable iff (rst)
    (word_valid && !word_stall && last_word) |=> (!word_valid || word_index == 5'd0))
    else $error("new packet does not start at word zero");

endmodule

`default_nettype wire
